// File: rtl/core/bclb_pkg.sv
// Shared widths, codes and types for the box-to-cell distance bounds block.
package bclb_pkg;

    localparam int SCALE_LOG2 = 44;
    localparam int COORD_BITS = 16;
    localparam int AXES       = 3;
    localparam int BOX_W      = 16;
    localparam int MID_W      = 17;
    localparam int BASIS_W    = 17;
    localparam int CELL_W     = 48;
    localparam int W_W        = MID_W + 1;          // 2*coord - midpoint
    localparam int PROD_W     = BASIS_W + CELL_W;   // basis times cell bound
    localparam int T_W        = PROD_W + 1;         // target per axis
    localparam int HALF_W     = 32;                 // split of |T| for squaring
    localparam int TOP_W      = T_W - HALF_W;
    localparam int SQ_W       = 2 * T_W;
    localparam int CSQ_W      = SQ_W - SCALE_LOG2;
    localparam int LSQ_W      = 2 * W_W;
    localparam int LT_W       = W_W + T_W;
    localparam int ACC_W      = 96;
    localparam int OUT_W      = 84;
    localparam int LO_W       = 64;
    localparam int HI_W       = OUT_W - LO_W;
    localparam int CFG_W      = 51;
    localparam int DIAM_W     = 34;
    localparam int CFG_IDX_W  = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MID     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASIS_A = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASIS_B = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIAM    = 2'd3;

    localparam logic [1:0] CORNER_FIRST = 2'd0;
    localparam logic [1:0] CORNER_LAST  = 2'd3;

    typedef logic signed [W_W-1:0]    wval_t;
    typedef logic signed [CELL_W-1:0] cell_t;
    typedef logic signed [ACC_W-1:0]  acc_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] corner;
    } tag_t;

endpackage

// File: rtl/core/bclb_issue.sv
// Input holding stage: takes one item and issues its four cell corners.
module bclb_issue
    import bclb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [BOX_W-1:0]     box_low [AXES],
    input  logic [BOX_W-1:0]     box_high [AXES],
    input  cell_t                cell_left,
    input  cell_t                cell_right,
    input  cell_t                cell_bottom,
    input  cell_t                cell_top,
    input  logic [CFG_W-1:0]     mid_packed,
    output tag_t                 tag_out,
    output cell_t                alpha,
    output cell_t                beta,
    output wval_t                w_low [AXES],
    output wval_t                w_high [AXES]
);

    logic       busy_reg, busy_next;
    logic [1:0] corner_reg, corner_next;
    logic       accept;
    wval_t      hlow_reg [AXES];
    wval_t      hhigh_reg [AXES];
    wval_t      low_calc [AXES];
    wval_t      high_calc [AXES];
    cell_t      left_reg, right_reg, bottom_reg, top_reg;
    tag_t       tag_reg;
    cell_t      alpha_reg, beta_reg;
    wval_t      olow_reg [AXES];
    wval_t      ohigh_reg [AXES];

    // a new item may enter while the last corner of the held one issues
    assign in_ready = en && (!busy_reg || corner_reg == CORNER_LAST);
    assign accept   = in_valid && in_ready;

    // offsets from the doubled midpoint
    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            low_calc[i]  = $signed({{(W_W-1-COORD_BITS){1'b0}}, box_low[i][COORD_BITS-1:0], 1'b0})
                         - $signed({1'b0, mid_packed[MID_W*i +: MID_W]});
            high_calc[i] = $signed({{(W_W-1-COORD_BITS){1'b0}}, box_high[i][COORD_BITS-1:0], 1'b0})
                         - $signed({1'b0, mid_packed[MID_W*i +: MID_W]});
        end
    end

    // corner sequencing
    always_comb
    begin
        busy_next   = busy_reg;
        corner_next = corner_reg;
        if (accept)
        begin
            busy_next   = 1'b1;
            corner_next = CORNER_FIRST;
        end
        else if (en && busy_reg)
        begin
            if (corner_reg == CORNER_LAST)
                busy_next = 1'b0;
            else
                corner_next = corner_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            corner_reg <= CORNER_FIRST;
            tag_reg    <= '0;
        end
        else
        begin
            busy_reg   <= busy_next;
            corner_reg <= corner_next;
            if (en)
            begin
                tag_reg.valid  <= busy_reg;
                tag_reg.corner <= corner_reg;
            end
        end
    end

    // held item payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hlow_reg   <= low_calc;
            hhigh_reg  <= high_calc;
            left_reg   <= cell_left;
            right_reg  <= cell_right;
            bottom_reg <= cell_bottom;
            top_reg    <= cell_top;
        end
        if (en)
        begin
            alpha_reg <= corner_reg[0] ? right_reg : left_reg;
            beta_reg  <= corner_reg[1] ? top_reg : bottom_reg;
            olow_reg  <= hlow_reg;
            ohigh_reg <= hhigh_reg;
        end
    end

    assign tag_out = tag_reg;
    assign alpha   = alpha_reg;
    assign beta    = beta_reg;
    assign w_low   = olow_reg;
    assign w_high  = ohigh_reg;

    a_no_ready_mid_item: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && corner_reg != CORNER_LAST |-> !in_ready)
        else $error("input taken before the held item issued its last corner");

    a_accept_starts_corner0: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg && corner_reg == CORNER_FIRST)
        else $error("accepted item does not start at the first corner");

endmodule

// File: rtl/core/bclb_corner_pipe.sv
// Six-stage datapath: per-corner sums of the per-axis minimum and maximum terms.
module bclb_corner_pipe
    import bclb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  tag_t              tag_in,
    input  cell_t             alpha,
    input  cell_t             beta,
    input  wval_t             w_low [AXES],
    input  wval_t             w_high [AXES],
    input  logic [CFG_W-1:0]  basis_a_packed,
    input  logic [CFG_W-1:0]  basis_b_packed,
    input  logic [DIAM_W-1:0] diameter_sq,
    output tag_t              tag_out,
    output acc_t              corner_min,
    output acc_t              corner_max
);

    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [T_W-1:0]    targ_t;
    typedef logic signed [LSQ_W-1:0]  lsq_t;
    typedef logic signed [LT_W-1:0]   lt_t;

    tag_t  tag1_reg, tag2_reg, tag3_reg, tag4_reg, tag5_reg, tag6_reg;

    // stage 1
    prod_t pa_reg [AXES];
    prod_t pb_reg [AXES];
    wval_t low1_reg [AXES];
    wval_t high1_reg [AXES];
    // stage 2
    targ_t t2_reg [AXES];
    logic  blow2_reg [AXES];
    logic  bhigh2_reg [AXES];
    lsq_t  lsq2_reg [AXES];
    lsq_t  hsq2_reg [AXES];
    wval_t low2_reg [AXES];
    wval_t high2_reg [AXES];
    // stage 3
    logic [2*TOP_W-1:0]        hh3_reg [AXES];
    logic [TOP_W+HALF_W-1:0]   hl3_reg [AXES];
    logic [2*HALF_W-1:0]       ll3_reg [AXES];
    lt_t   lt3_reg [AXES];
    lt_t   ht3_reg [AXES];
    lsq_t  lsq3_reg [AXES];
    lsq_t  hsq3_reg [AXES];
    logic  blow3_reg [AXES];
    logic  bhigh3_reg [AXES];
    // stage 4
    logic [CSQ_W-1:0] csq4_reg [AXES];
    acc_t  vl4_reg [AXES];
    acc_t  vh4_reg [AXES];
    logic  blow4_reg [AXES];
    logic  bhigh4_reg [AXES];
    // stage 5
    acc_t  mn5_reg [AXES];
    acc_t  mx5_reg [AXES];
    // stage 6
    acc_t  mn6_reg, mx6_reg;

    acc_t  base;
    targ_t mag [AXES];
    logic [SQ_W-1:0] sq_sum [AXES];

    assign base = -$signed(ACC_W'(diameter_sq) << SCALE_LOG2);

    // magnitude of the target and its rounded-up square over the scale
    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            mag[i]    = t2_reg[i][T_W-1] ? -t2_reg[i] : t2_reg[i];
            sq_sum[i] = (SQ_W'(hh3_reg[i]) << (2*HALF_W))
                      + (SQ_W'(hl3_reg[i]) << (HALF_W+1))
                      + SQ_W'(ll3_reg[i])
                      + ((SQ_W'(1) << SCALE_LOG2) - SQ_W'(1));
        end
    end

    // valid and corner travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
            tag4_reg <= '0;
            tag5_reg <= '0;
            tag6_reg <= '0;
        end
        else if (en)
        begin
            tag1_reg <= tag_in;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
            tag4_reg <= tag3_reg;
            tag5_reg <= tag4_reg;
            tag6_reg <= tag5_reg;
        end
    end

    // datapath stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                // targets: basis component times cell bound
                pa_reg[i]    <= PROD_W'($signed(basis_a_packed[BASIS_W*i +: BASIS_W]))
                              * PROD_W'(alpha);
                pb_reg[i]    <= PROD_W'($signed(basis_b_packed[BASIS_W*i +: BASIS_W]))
                              * PROD_W'(beta);
                low1_reg[i]  <= w_low[i];
                high1_reg[i] <= w_high[i];

                // sum, clamp tests, endpoint squares
                t2_reg[i]     <= T_W'(pa_reg[i]) + T_W'(pb_reg[i]);
                blow2_reg[i]  <= ((T_W+1)'(pa_reg[i]) + (T_W+1)'(pb_reg[i]))
                               < ((T_W+1)'(low1_reg[i]) <<< SCALE_LOG2);
                bhigh2_reg[i] <= ((T_W+1)'(high1_reg[i]) <<< SCALE_LOG2)
                               < ((T_W+1)'(pa_reg[i]) + (T_W+1)'(pb_reg[i]));
                lsq2_reg[i]   <= LSQ_W'(low1_reg[i]) * LSQ_W'(low1_reg[i]);
                hsq2_reg[i]   <= LSQ_W'(high1_reg[i]) * LSQ_W'(high1_reg[i]);
                low2_reg[i]   <= low1_reg[i];
                high2_reg[i]  <= high1_reg[i];

                // partial products of T^2, endpoint times T
                hh3_reg[i]    <= (2*TOP_W)'(mag[i][T_W-1:HALF_W])
                               * (2*TOP_W)'(mag[i][T_W-1:HALF_W]);
                hl3_reg[i]    <= (TOP_W+HALF_W)'(mag[i][T_W-1:HALF_W])
                               * (TOP_W+HALF_W)'(mag[i][HALF_W-1:0]);
                ll3_reg[i]    <= (2*HALF_W)'(mag[i][HALF_W-1:0])
                               * (2*HALF_W)'(mag[i][HALF_W-1:0]);
                lt3_reg[i]    <= LT_W'(low2_reg[i]) * LT_W'(t2_reg[i]);
                ht3_reg[i]    <= LT_W'(high2_reg[i]) * LT_W'(t2_reg[i]);
                lsq3_reg[i]   <= lsq2_reg[i];
                hsq3_reg[i]   <= hsq2_reg[i];
                blow3_reg[i]  <= blow2_reg[i];
                bhigh3_reg[i] <= bhigh2_reg[i];

                // endpoint values Q*w^2 - 2*T*w and ceil(T^2/Q)
                csq4_reg[i]   <= sq_sum[i][SQ_W-1:SCALE_LOG2];
                vl4_reg[i]    <= (ACC_W'(lsq3_reg[i]) <<< SCALE_LOG2)
                               - (ACC_W'(lt3_reg[i]) <<< 1);
                vh4_reg[i]    <= (ACC_W'(hsq3_reg[i]) <<< SCALE_LOG2)
                               - (ACC_W'(ht3_reg[i]) <<< 1);
                blow4_reg[i]  <= blow3_reg[i];
                bhigh4_reg[i] <= bhigh3_reg[i];

                // per-axis max at an endpoint, min at the clamped vertex
                mx5_reg[i] <= (vl4_reg[i] < vh4_reg[i]) ? vh4_reg[i] : vl4_reg[i];
                if (blow4_reg[i])
                    mn5_reg[i] <= vl4_reg[i];
                else if (bhigh4_reg[i])
                    mn5_reg[i] <= vh4_reg[i];
                else
                    mn5_reg[i] <= -$signed(ACC_W'(csq4_reg[i]));
            end

            // axis sums on top of the diameter term
            mn6_reg <= base + mn5_reg[0] + mn5_reg[1] + mn5_reg[2];
            mx6_reg <= base + mx5_reg[0] + mx5_reg[1] + mx5_reg[2];
        end
    end

    assign tag_out    = tag6_reg;
    assign corner_min = mn6_reg;
    assign corner_max = mx6_reg;

    a_corner_order: assert property (@(posedge clk) disable iff (!rst_n)
        en && tag6_reg.valid && tag6_reg.corner != CORNER_LAST
        |=> tag6_reg.valid && tag6_reg.corner == $past(tag6_reg.corner) + 2'd1)
        else $error("corners of one item left the datapath out of order");

endmodule

// File: rtl/core/bclb_reduce.sv
// Min/max over the four corners, saturation and the result register.
module bclb_reduce
    import bclb_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    output logic            en,
    input  tag_t            tag_in,
    input  acc_t            corner_min,
    input  acc_t            corner_max,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [LO_W-1:0] lower_bound_lo,
    output logic [HI_W-1:0] lower_bound_hi,
    output logic [LO_W-1:0] upper_bound_lo,
    output logic [HI_W-1:0] upper_bound_hi
);

    localparam acc_t SAT_MAX = (acc_t'(1) <<< (OUT_W-1)) - acc_t'(1);
    localparam acc_t SAT_MIN = -(acc_t'(1) <<< (OUT_W-1));

    function automatic logic [OUT_W-1:0] saturate(input acc_t v);
        acc_t r;
        r = v;
        if (SAT_MAX < r)
            r = SAT_MAX;
        if (r < SAT_MIN)
            r = SAT_MIN;
        return r[OUT_W-1:0];
    endfunction

    logic             out_valid_reg;
    acc_t             best_min_reg, best_max_reg;
    acc_t             cur_min, cur_max;
    logic [OUT_W-1:0] lower_reg, upper_reg;
    logic             finish;

    // pipeline stalls only when a finished result would overwrite a waiting one
    assign finish = tag_in.valid && tag_in.corner == CORNER_LAST;
    assign en     = !(finish && out_valid_reg && !out_ready);

    // running extremes, first corner starts fresh
    always_comb
    begin
        if (tag_in.corner == CORNER_FIRST)
        begin
            cur_min = corner_min;
            cur_max = corner_max;
        end
        else
        begin
            cur_min = (corner_min < best_min_reg) ? corner_min : best_min_reg;
            cur_max = (best_max_reg < corner_max) ? corner_max : best_max_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en && finish)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (en && tag_in.valid)
        begin
            best_min_reg <= cur_min;
            best_max_reg <= cur_max;
        end
        if (en && finish)
        begin
            lower_reg <= saturate(cur_min);
            upper_reg <= saturate(cur_max);
        end
    end

    assign out_valid      = out_valid_reg;
    assign lower_bound_lo = lower_reg[LO_W-1:0];
    assign lower_bound_hi = lower_reg[OUT_W-1:LO_W];
    assign upper_bound_lo = upper_reg[LO_W-1:0];
    assign upper_bound_hi = upper_reg[OUT_W-1:LO_W];

    a_result_from_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(finish))
        else $error("result raised without a last-corner transfer");

    a_bounds_ordered_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !$past(en) |-> $stable(lower_reg) && $stable(upper_reg))
        else $error("result register changed while the pipeline was stalled");

endmodule

// File: rtl/core/box_cell_lifted_distance_bounds_top.sv
// Top level of the box-to-cell lifted distance bounds block.
// Takes one box/cell item and returns one lower and one upper bound (84-bit
// signed, each split into a 64-bit low word and a 20-bit signed high word,
// saturated). The four cell corners go through a six-stage product datapath
// one corner per cycle while not stalled; a new item is taken as the last
// corner of the held one issues; that corner issue rate sets the throughput.
// Back pressure on the result side stalls the pipeline only when the next
// finished result reaches the output while one still waits; until then the
// input keeps being taken while a finished result waits in the output
// register. Configuration registers are written through cfg_we/
// cfg_index/cfg_data and must only change while no item is in flight.
module box_cell_lifted_distance_bounds_top
    import bclb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // box_low_x, box_low_y, box_low_z, box_high_x, box_high_y, box_high_z,
    // cell_left, cell_right, cell_bottom, cell_top
    input  logic [287:0]         s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // lower_bound_lo, lower_bound_hi, upper_bound_lo, upper_bound_hi
    output logic [167:0]         m_axis_tdata,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic [CFG_W-1:0]  mid_reg, basis_a_reg, basis_b_reg;
    logic [DIAM_W-1:0] diam_reg;

    logic              en;
    logic [BOX_W-1:0]  box_low [AXES];
    logic [BOX_W-1:0]  box_high [AXES];
    tag_t              tag0, tag6;
    cell_t             alpha, beta;
    wval_t             w_low [AXES];
    wval_t             w_high [AXES];
    acc_t              corner_min, corner_max;
    logic [LO_W-1:0]   lower_lo, upper_lo;
    logic [HI_W-1:0]   lower_hi, upper_hi;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_reg     <= '0;
            basis_a_reg <= '0;
            basis_b_reg <= '0;
            diam_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MID:     mid_reg     <= cfg_data;
                CFG_BASIS_A: basis_a_reg <= cfg_data;
                CFG_BASIS_B: basis_b_reg <= cfg_data;
                CFG_DIAM:    diam_reg    <= cfg_data[DIAM_W-1:0];
                default:     ;
            endcase
        end
    end

    // unpack the input transfer
    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            box_low[i]  = s_axis_tdata[BOX_W*i +: BOX_W];
            box_high[i] = s_axis_tdata[BOX_W*(AXES+i) +: BOX_W];
        end
    end

    bclb_issue u_issue (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .box_low     (box_low),
        .box_high    (box_high),
        .cell_left   (s_axis_tdata[96 +: CELL_W]),
        .cell_right  (s_axis_tdata[144 +: CELL_W]),
        .cell_bottom (s_axis_tdata[192 +: CELL_W]),
        .cell_top    (s_axis_tdata[240 +: CELL_W]),
        .mid_packed  (mid_reg),
        .tag_out     (tag0),
        .alpha       (alpha),
        .beta        (beta),
        .w_low       (w_low),
        .w_high      (w_high)
    );

    bclb_corner_pipe u_pipe (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (en),
        .tag_in         (tag0),
        .alpha          (alpha),
        .beta           (beta),
        .w_low          (w_low),
        .w_high         (w_high),
        .basis_a_packed (basis_a_reg),
        .basis_b_packed (basis_b_reg),
        .diameter_sq    (diam_reg),
        .tag_out        (tag6),
        .corner_min     (corner_min),
        .corner_max     (corner_max)
    );

    bclb_reduce u_reduce (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (en),
        .tag_in         (tag6),
        .corner_min     (corner_min),
        .corner_max     (corner_max),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .lower_bound_lo (lower_lo),
        .lower_bound_hi (lower_hi),
        .upper_bound_lo (upper_lo),
        .upper_bound_hi (upper_hi)
    );

    assign m_axis_tdata = {upper_hi, upper_lo, lower_hi, lower_lo};

endmodule

// File: tb/sv/tb_box_cell_lifted_distance_bounds_top.sv
// Self-checking testbench for the box-to-cell lifted distance bounds block.
module tb_box_cell_lifted_distance_bounds_top;
    import bclb_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 30;

    typedef logic signed [191:0] big_t;

    // Packed to match s_axis_tdata: box_lo[x,y,z], box_hi[x,y,z], left, right, bottom, top
    typedef struct packed {
        cell_t                           top;
        cell_t                           bottom;
        cell_t                           right;
        cell_t                           left;
        logic [AXES-1:0][BOX_W-1:0]      box_hi;
        logic [AXES-1:0][BOX_W-1:0]      box_lo;
    } box_item_t;

    // Packed to match m_axis_tdata: lower lo/hi, upper lo/hi
    typedef struct packed {
        logic signed [HI_W-1:0] ub_hi;
        logic [LO_W-1:0]        ub_lo;
        logic signed [HI_W-1:0] lb_hi;
        logic [LO_W-1:0]        lb_lo;
    } bounds_t;

    typedef struct packed {
        logic [CFG_W-1:0]  mid;
        logic [CFG_W-1:0]  basis_a;
        logic [CFG_W-1:0]  basis_b;
        logic [DIAM_W-1:0] diam;
    } cfg_t;

    typedef struct {
        cfg_t      cfg;
        box_item_t item;
        bit        typed_exp;
        bounds_t   exp;
    } dir_row_t;

    logic            clk;
    logic            rst_n;
    logic            s_axis_tvalid;
    logic            s_axis_tready;
    box_item_t       s_axis_tdata;
    logic            m_axis_tvalid;
    logic            m_axis_tready;
    logic [167:0]    m_axis_tdata;
    logic            cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    cfg_t      cur_cfg;
    bounds_t   pending_bounds[$];
    dir_row_t  dir_rows[$];
    int        fail_count;
    int        cycle_count;
    int        send_idle_pct;
    int        recv_stall_pct;

    box_cell_lifted_distance_bounds_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Clock
    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Clamp to the 84-bit signed output range
    function automatic logic [OUT_W-1:0] clamp_out(big_t v);
        big_t top_v;
        top_v = (big_t'(1) <<< (OUT_W - 1)) - 1;
        if (v > top_v)
            v = top_v;
        if (v < -top_v - 1)
            v = -top_v - 1;
        return v[OUT_W-1:0];
    endfunction

    // Lower and upper bound over the four cell corners
    function automatic bounds_t predict_bounds(box_item_t it, cfg_t c);
        big_t    lw[AXES];
        big_t    hw[AXES];
        big_t    av[AXES];
        big_t    bv[AXES];
        big_t    base, al, be, t, vl, vh, mn, mx, best_mn, best_mx, round_up;
        logic [OUT_W-1:0] s;
        bounds_t r;
        round_up = (big_t'(1) <<< SCALE_LOG2) - 1;
        for (int ax = 0; ax < AXES; ax++)
        begin
            lw[ax] = big_t'(it.box_lo[ax]) * 2 - big_t'(c.mid[MID_W*ax +: MID_W]);
            hw[ax] = big_t'(it.box_hi[ax]) * 2 - big_t'(c.mid[MID_W*ax +: MID_W]);
            av[ax] = $signed(c.basis_a[BASIS_W*ax +: BASIS_W]);
            bv[ax] = $signed(c.basis_b[BASIS_W*ax +: BASIS_W]);
        end
        base    = -(big_t'(c.diam) <<< SCALE_LOG2);
        best_mn = base;
        best_mx = base;
        for (int cn = 0; cn < 4; cn++)
        begin
            al = cn[0] ? it.right : it.left;
            be = cn[1] ? it.top : it.bottom;
            mn = base;
            mx = base;
            for (int ax = 0; ax < AXES; ax++)
            begin
                t  = av[ax] * al + bv[ax] * be;
                vl = ((lw[ax] * lw[ax]) <<< SCALE_LOG2) - lw[ax] * (t <<< 1);
                vh = ((hw[ax] * hw[ax]) <<< SCALE_LOG2) - hw[ax] * (t <<< 1);
                mx = mx + ((vl < vh) ? vh : vl);
                // low end tested first, then high end, else the vertex
                if (t < (lw[ax] <<< SCALE_LOG2))
                    mn = mn + vl;
                else if ((hw[ax] <<< SCALE_LOG2) < t)
                    mn = mn + vh;
                else
                    mn = mn - ((t * t + round_up) >>> SCALE_LOG2);
            end
            if (cn == 0 || mn < best_mn)
                best_mn = mn;
            if (cn == 0 || best_mx < mx)
                best_mx = mx;
        end
        s = clamp_out(best_mn);
        r.lb_lo = s[LO_W-1:0];
        r.lb_hi = s[OUT_W-1:LO_W];
        s = clamp_out(best_mx);
        r.ub_lo = s[LO_W-1:0];
        r.ub_hi = s[OUT_W-1:LO_W];
        return r;
    endfunction

    function automatic box_item_t mk_item(logic [15:0] lx, logic [15:0] ly, logic [15:0] lz,
                                          logic [15:0] hx, logic [15:0] hy, logic [15:0] hz,
                                          cell_t l, cell_t r, cell_t b, cell_t t);
        box_item_t it;
        it.box_lo = {lz, ly, lx};
        it.box_hi = {hz, hy, hx};
        it.left   = l;
        it.right  = r;
        it.bottom = b;
        it.top    = t;
        return it;
    endfunction

    function automatic cell_t rand_cell();
        if ($urandom_range(0, 3) == 0)
            return cell_t'({$urandom, $urandom});
        return cell_t'($signed({$urandom, $urandom}) >>> $urandom_range(16, 46));
    endfunction

    function automatic box_item_t rand_item();
        box_item_t it;
        int        kind;
        kind = $urandom_range(0, 9);
        for (int ax = 0; ax < AXES; ax++)
        begin
            it.box_lo[ax] = 16'($urandom);
            if (kind < 7)
                it.box_hi[ax] = it.box_lo[ax] + 16'($urandom_range(0, 4095));
            else if (kind == 7)
                it.box_hi[ax] = it.box_lo[ax];
            else
                it.box_hi[ax] = 16'($urandom);
        end
        it.left   = rand_cell();
        it.bottom = rand_cell();
        if (kind < 9)
        begin
            it.right = it.left + cell_t'({$urandom, $urandom} >> $urandom_range(16, 63));
            it.top   = it.bottom + cell_t'({$urandom, $urandom} >> $urandom_range(16, 63));
        end
        else
        begin
            it.right = rand_cell();
            it.top   = rand_cell();
        end
        return it;
    endfunction

    // Append one directed row
    task automatic add_row(cfg_t c, box_item_t it, bit typed_exp, bounds_t exp);
        dir_row_t row;
        row.cfg       = c;
        row.item      = it;
        row.typed_exp = typed_exp;
        row.exp       = exp;
        dir_rows.insert(dir_rows.size(), row);
    endtask

    // Write all registers once the block is idle
    task automatic write_config(cfg_t c);
        s_axis_tvalid <= 1'b0;
        while (pending_bounds.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MID;
        cfg_data  <= c.mid;
        @(posedge clk);
        cfg_index <= CFG_BASIS_A;
        cfg_data  <= c.basis_a;
        @(posedge clk);
        cfg_index <= CFG_BASIS_B;
        cfg_data  <= c.basis_b;
        @(posedge clk);
        cfg_index <= CFG_DIAM;
        cfg_data  <= CFG_W'(c.diam);
        @(posedge clk);
        cfg_we  <= 1'b0;
        cur_cfg = c;
    endtask

    // Offer one item; returns right after the transfer edge
    task automatic send_box_item(box_item_t it, bit typed_exp, bounds_t exp);
        bit fire;
        while (send_idle_pct != 0 && $urandom_range(1, 100) <= send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= it;
        fire = 1'b0;
        while (!fire)
        begin
            @(negedge clk);
            fire = s_axis_tready;
            @(posedge clk);
        end
        pending_bounds.insert(pending_bounds.size(),
                              typed_exp ? exp : predict_bounds(it, cur_cfg));
    endtask

    task automatic check_field(string name, logic [LO_W-1:0] exp, logic [LO_W-1:0] act);
        if (exp !== act)
        begin
            $display("%0t mismatch %s: expected %h actual %h", $time, name, exp, act);
            fail_count++;
        end
    endtask

    // Receiver back pressure
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(1, 100) > recv_stall_pct);

    // Result check; everything is stable between the falling and rising edge
    always @(negedge clk)
    begin
        bounds_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (pending_bounds.size() == 0)
            begin
                $display("%0t unexpected result: expected none actual %h", $time, got);
                fail_count++;
            end
            else
            begin
                want = pending_bounds.pop_front();
                check_field("lower_bound_lo", want.lb_lo, got.lb_lo);
                check_field("lower_bound_hi", LO_W'(want.lb_hi), LO_W'(got.lb_hi));
                check_field("upper_bound_lo", want.ub_lo, got.ub_lo);
                check_field("upper_bound_hi", LO_W'(want.ub_hi), LO_W'(got.ub_hi));
            end
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("[box_cell_lifted_distance_bounds_top] ERROR");
            $finish;
        end
    end

    initial
    begin
        cfg_t      c_zero, c_mix, c_sat, c_rand;
        cell_t     cmin, cmax, one;
        bounds_t   none, sat_lo, sat_hi;
        box_item_t it;

        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_MID;
        cfg_data       = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;

        cmin   = {1'b1, {(CELL_W-1){1'b0}}};
        cmax   = {1'b0, {(CELL_W-1){1'b1}}};
        one    = cell_t'(1) <<< SCALE_LOG2;
        none   = '0;
        c_zero = '0;
        c_mix  = '{mid:     {17'd65535, 17'h1FFFF, 17'd0},
                   basis_a: {17'h00400, 17'h1F000, 17'h01000},
                   basis_b: {17'h0FFFF, 17'h00010, 17'h10000},
                   diam:    {DIAM_W{1'b1}}};
        // most negative basis: targets of about 2^64 push both bounds past the range
        c_sat  = '{mid: '0, basis_a: {3{17'h10000}}, basis_b: {3{17'h10000}}, diam: '0};
        sat_lo = '{ub_hi: 20'h80000, ub_lo: '0, lb_hi: 20'h80000, lb_lo: '0};
        sat_hi = '{ub_hi: 20'h7FFFF, ub_lo: '1, lb_hi: 20'h7FFFF, lb_lo: '1};

        // Directed stimulus
        add_row(c_zero, mk_item(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, none);
        add_row(c_zero, mk_item(0, 0, 0, 0, 0, 0, cmin, cmax, cmin, cmax), 1, none);
        add_row(c_zero, mk_item('1, '1, '1, '1, '1, '1, 0, 0, 0, 0), 0, none);
        add_row(c_mix, mk_item(0, 0, 0, '1, '1, '1, -one, one, -one, one), 0, none);
        add_row(c_mix, mk_item(100, 200, 300, 100, 200, 300, 0, one, 0, one), 0, none);
        add_row(c_mix, mk_item('1, '1, '1, 0, 0, 0, one, -one, one, -one), 0, none);
        add_row(c_mix, mk_item(0, 0, 0, '1, '1, '1, cmin, cmax, cmin, cmax), 0, none);
        add_row(c_mix, mk_item(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
                               16'hAAAA, cmax, cmin, cmax, cmin), 0, none);
        add_row(c_mix, mk_item(30000, 30000, 30000, 40000, 40000, 40000,
                               one >>> 4, one, one >>> 4, one), 0, none);
        add_row(c_sat, mk_item('1, '1, '1, '1, '1, '1, cmin, cmin, cmin, cmin),
                1, sat_lo);
        add_row(c_sat, mk_item('1, '1, '1, '1, '1, '1, cmax, cmax, cmax, cmax),
                1, sat_hi);
        add_row(c_sat, mk_item(0, 0, 0, '1, '1, '1, -one, one, 0, 0), 0, none);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        cur_cfg = c_zero;

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].cfg != cur_cfg)
                write_config(dir_rows[i].cfg);
            send_box_item(dir_rows[i].item, dir_rows[i].typed_exp, dir_rows[i].exp);
        end

        // Random phases, each with its own settings and idling mix
        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph == 1)
                c_rand = '{mid: '1, basis_a: {3{17'h0FFFF}}, basis_b: {3{17'h10000}},
                           diam: '1};
            else if (ph == 2)
                c_rand = c_zero;
            else if (ph == 5)
                c_rand = '{mid: '0, basis_a: {3{17'h1FFFF}}, basis_b: {3{17'h00001}},
                           diam: '1};
            else
                c_rand = '{mid: CFG_W'({$urandom, $urandom}),
                           basis_a: CFG_W'({$urandom, $urandom}),
                           basis_b: CFG_W'({$urandom, $urandom}),
                           diam: DIAM_W'({$urandom, $urandom})};
            write_config(c_rand);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            for (int n = 0; n < 250; n++)
            begin
                it = rand_item();
                send_box_item(it, 1'b0, none);
            end
        end
        s_axis_tvalid <= 1'b0;

        while (pending_bounds.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("[box_cell_lifted_distance_bounds_top] OK");
        else
            $display("[box_cell_lifted_distance_bounds_top] ERROR");
        $finish;
    end

endmodule
